>>> sv/ski_pkg.sv
// ----------------------------------------------------------------------------
// ski_pkg
// Shared types and constants of the servo keyframe interpolator.
// ----------------------------------------------------------------------------
`default_nettype none
package ski_pkg;
    localparam int ANGLE_W = 10;
    localparam int TIME_W = 32;
    localparam int DUR_W = 16;
    localparam int STEP_W = 7;
    localparam int MIN_STEP_MS = 25;
    localparam int NUM_SERVO_FIELDS = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_FRAME,
        ST_ANGLE,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

>>> sv/ski_divider.sv
// ----------------------------------------------------------------------------
// ski_divider
// Restoring divider, one quotient bit per cycle, for unsigned operands.
// ----------------------------------------------------------------------------
`default_nettype none
module ski_divider #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 7
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  busy,
    output logic [NUM_W-1:0]      quot,
    output logic [DEN_W-1:0]      rem
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] r_reg, r_next, d_reg, d_next;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        cnt_next = cnt_reg;
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        trial = {r_reg, q_reg[NUM_W-1]} - {1'b0, d_reg};
        if (start)
        begin
            cnt_next = CNT_W'(NUM_W);
            q_next = num;
            r_next = '0;
            d_next = den;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            // The shifted remainder fits in DEN_W+1 bits; keep it only if no borrow.
            if (!trial[DEN_W] || r_reg[DEN_W-1])
            begin
                r_next = trial[DEN_W-1:0];
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[DEN_W-2:0], q_reg[NUM_W-1]};
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = cnt_reg != '0;
    assign quot = q_reg;
    assign rem = r_reg;
endmodule
`default_nettype wire

>>> sv/servo_keyframe_interpolator.sv
// ----------------------------------------------------------------------------
// servo_keyframe_interpolator
// Linear keyframe interpolation of servo poses into timed frames.
// ----------------------------------------------------------------------------
// An initial pose gives one word on the cycle after acceptance.
// A later pose first divides its duration by the step count for the slot, then
// each frame has a setup state, one division per servo in the shared serial
// divider and an output state that waits for m_tready.
// One pose is worked on at a time. Reset clears time, pose and control.
`default_nettype none
module servo_keyframe_interpolator #(
    parameter int SERVO_COUNT = 8,
    parameter int MAX_STEPS = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata: step_count[6:0], duration[22:7], target_0..7 [32:23]..[102:93]
    input  wire logic [103:0] s_tdata,
    // tuser: is_initial
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata: fire_time[31:0], out_angle_0..7 [41:32]..[111:102]
    output logic [111:0]      m_tdata,
    output logic              m_tlast
);
    import ski_pkg::*;

    localparam int SI_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
    localparam int PROD_W = ANGLE_W + STEP_W + 1;

    state_t state_reg, state_next;
    logic [TIME_W-1:0]  elapsed_reg, elapsed_next, time_reg, time_next;
    logic [TIME_W-1:0]  slot_reg, slot_next;
    logic [DUR_W-1:0]   dur_reg, dur_next;
    logic [STEP_W-1:0]  steps_reg, steps_next, j_reg, j_next;
    logic [SI_W-1:0]    si_reg, si_next;
    logic [ANGLE_W-1:0] prev_reg [NUM_SERVO_FIELDS];
    logic [ANGLE_W-1:0] tgt_reg [NUM_SERVO_FIELDS];
    logic [ANGLE_W-1:0] ang_reg [NUM_SERVO_FIELDS];
    logic               last_reg, last_next, init_reg, init_next;
    logic               neg_reg;

    logic               div_start;
    logic               div_busy;
    logic [DUR_W-1:0]   div_num;
    logic [STEP_W-1:0]  div_den;
    logic [DUR_W-1:0]   dnum, dquot;
    logic [STEP_W-1:0]  drem;
    logic [PROD_W-1:0]  prod;
    logic [STEP_W-1:0]  steps_in;
    logic               angle_write;
    logic signed [ANGLE_W+1:0] diff, quot_s, angle_val;

    ski_divider #(.NUM_W(DUR_W), .DEN_W(STEP_W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den(div_den), .busy(div_busy), .quot(dquot), .rem(drem)
    );

    // The divider loads its operands at the start edge, so they are formed here.
    assign div_num = (state_reg == ST_IDLE) ? s_tdata[22:7] : dnum;
    assign div_den = (state_reg == ST_IDLE) ? steps_in : steps_reg;

    always_comb
    begin
        steps_in = s_tdata[6:0];
        if (steps_in == '0)
            steps_in = STEP_W'(1);
        else if (steps_in > STEP_W'(MAX_STEPS))
            steps_in = STEP_W'(MAX_STEPS);
    end

    // Difference of the servo divided next and the numerator magnitude |diff| * j.
    always_comb
    begin
        diff = $signed({2'b0, tgt_reg[si_next]}) - $signed({2'b0, prev_reg[si_next]});
        prod = PROD_W'((diff < 0) ? -diff : diff) * PROD_W'(j_next);
        dnum = prod[DUR_W-1:0];
        // Negative quotients round toward minus infinity.
        quot_s = $signed({2'b0, dquot[ANGLE_W-1:0]});
        if (neg_reg)
            quot_s = -quot_s - ((drem != '0) ? 12'sd1 : 12'sd0);
        angle_val = $signed({2'b0, prev_reg[si_reg]}) + quot_s;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                    state_next = s_tuser ? ST_OUT : ST_DIV;
            ST_DIV:
                if (!div_busy && !div_start)
                    state_next = ST_FRAME;
            ST_FRAME:
                state_next = ST_ANGLE;
            ST_ANGLE:
                if (!div_busy && !div_start && si_reg == SI_W'(SERVO_COUNT - 1))
                    state_next = ST_OUT;
            ST_OUT:
                if (m_tready)
                    state_next = (init_reg || last_reg) ? ST_IDLE : ST_FRAME;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and handshake outputs.
    always_comb
    begin
        s_tready = state_reg == ST_IDLE;
        m_tvalid = state_reg == ST_OUT;
        elapsed_next = elapsed_reg;
        time_next = time_reg;
        slot_next = slot_reg;
        dur_next = dur_reg;
        steps_next = steps_reg;
        j_next = j_reg;
        si_next = si_reg;
        last_next = last_reg;
        init_next = init_reg;
        div_start = 1'b0;
        angle_write = 1'b0;
        case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                begin
                    init_next = s_tuser;
                    steps_next = steps_in;
                    dur_next = s_tdata[22:7];
                    j_next = '0;
                    last_next = s_tuser;
                    if (s_tuser)
                    begin
                        elapsed_next = '0;
                        time_next = '0;
                    end
                    else
                        time_next = elapsed_reg;
                    div_start = !s_tuser;
                end
            ST_DIV:
                if (!div_busy && !div_start)
                    slot_next = (dquot < DUR_W'(MIN_STEP_MS))
                        ? TIME_W'(MIN_STEP_MS) : TIME_W'(dquot);
            ST_FRAME:
            begin
                j_next = j_reg + 1'b1;
                time_next = time_reg + slot_reg;
                last_next = (j_reg + 1'b1) == steps_reg;
                si_next = '0;
                div_start = 1'b1;
            end
            ST_ANGLE:
                if (!div_busy && !div_start)
                begin
                    angle_write = 1'b1;
                    if (si_reg != SI_W'(SERVO_COUNT - 1))
                    begin
                        si_next = si_reg + 1'b1;
                        div_start = 1'b1;
                    end
                end
            ST_OUT:
                if (m_tready && !init_reg && last_reg)
                    elapsed_next = elapsed_reg + TIME_W'(dur_reg);
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            elapsed_reg <= '0;
            for (int i = 0; i < NUM_SERVO_FIELDS; i++)
                prev_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            elapsed_reg <= elapsed_next;
            if (state_reg == ST_OUT && m_tready && (init_reg || last_reg))
                for (int i = 0; i < SERVO_COUNT; i++)
                    prev_reg[i] <= tgt_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        slot_reg <= slot_next;
        dur_reg <= dur_next;
        steps_reg <= steps_next;
        j_reg <= j_next;
        si_reg <= si_next;
        last_reg <= last_next;
        init_reg <= init_next;
        if (div_start)
            neg_reg <= (state_reg != ST_IDLE) && (diff < 0);
        // On acceptance, capture every target; the output angles start at the targets.
        if (state_reg == ST_IDLE && s_tvalid)
            for (int i = 0; i < NUM_SERVO_FIELDS; i++)
            begin
                tgt_reg[i] <= (i < SERVO_COUNT) ? s_tdata[23 + i*ANGLE_W +: ANGLE_W] : '0;
                ang_reg[i] <= (i < SERVO_COUNT) ? s_tdata[23 + i*ANGLE_W +: ANGLE_W] : '0;
            end
        if (angle_write)
            ang_reg[si_reg] <= angle_val[ANGLE_W-1:0];
    end

    // dnum for servo si+1 must be formed before start; si_next leads it.
    always_comb
    begin
        m_tdata[TIME_W-1:0] = time_reg;
        for (int i = 0; i < NUM_SERVO_FIELDS; i++)
            m_tdata[TIME_W + i*ANGLE_W +: ANGLE_W] = ang_reg[i];
        m_tlast = last_reg;
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid) else $error("accepting while output pending");
    a_init_time: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && init_reg) |-> (time_reg == '0 && m_tlast))
        else $error("initial frame malformed");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> !div_busy) else $error("divider busy at output");
endmodule
`default_nettype wire
